[sv/zrle_pkg.sv]
// zero run-length encoder: shared widths, result and work types, encode steps
// no dependencies; used by the channel interfaces and the core
package zrle_pkg;

  localparam int BYTE_W        = 8;
  localparam int LEN_W         = 12;
  localparam int MAX_PKT_BYTES = 2048;
  localparam int MAX_RES       = 4;
  localparam int NRES_W        = $clog2(MAX_RES + 1);
  localparam int SLOT_W        = $clog2(MAX_RES);
  localparam int QDEPTH        = 4;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] ZERO_MARK = 8'h00;
  localparam logic [BYTE_W-1:0] RUN_MAX   = 8'hFF;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              packet_done;
    logic              overflow_fail;
    logic [LEN_W-1:0]  total_length;
  } res_t;

  typedef struct packed {
    logic [NRES_W-1:0]      n;
    res_t [MAX_RES-1:0]     res;
  } group_t;

  typedef struct packed {
    logic              run;
    logic [BYTE_W-1:0] xcnt;
    logic [LEN_W-1:0]  ecnt;
    logic              failed;
    logic [LEN_W-1:0]  cap;
    group_t            grp;
  } work_t;

  function automatic work_t put_res(work_t w, logic [BYTE_W-1:0] b, logic has, logic done);
    work_t o;
    o = w;
    o.grp.res[w.grp.n[SLOT_W-1:0]] = '{out_byte: b, has_byte: has, packet_done: done,
                                      overflow_fail: w.failed, total_length: w.ecnt};
    o.grp.n = w.grp.n + NRES_W'(1);
    return o;
  endfunction

  function automatic work_t emit_byte(work_t w, logic [BYTE_W-1:0] b);
    work_t o;
    o = w;
    if (!w.failed) begin
      if (w.ecnt >= w.cap) begin
        o.failed = 1'b1;
      end else begin
        o.ecnt = w.ecnt + LEN_W'(1);
        o = put_res(o, b, 1'b1, 1'b0);
      end
    end
    return o;
  endfunction

  // marker only goes out if its count byte fits too
  function automatic work_t start_run(work_t w);
    work_t o;
    o = w;
    o.run  = 1'b1;
    o.xcnt = '0;
    if (!w.failed) begin
      if (({1'b0, w.ecnt} + (LEN_W+1)'(2)) > {1'b0, w.cap}) begin
        o.failed = 1'b1;
      end else begin
        o = emit_byte(o, ZERO_MARK);
      end
    end
    return o;
  endfunction

  function automatic work_t close_run(work_t w);
    work_t o;
    o = w;
    if (w.run) begin
      o = emit_byte(o, w.xcnt);
    end
    o.run  = 1'b0;
    o.xcnt = '0;
    return o;
  endfunction

endpackage

[sv/zrle_in_if.sv]
// input channel of the zero run-length encoder: raw packet bytes
// depends on zrle_pkg for field widths
interface zrle_in_if import zrle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_packet;
  logic [LEN_W-1:0]  capacity;

  modport source (output valid, in_byte, end_of_packet, capacity, input ready);
  modport sink   (input valid, in_byte, end_of_packet, capacity, output ready);
endinterface

[sv/zrle_out_if.sv]
// result channel of the zero run-length encoder: compressed bytes and status
// depends on zrle_pkg for field widths
interface zrle_out_if import zrle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              has_byte;
  logic              packet_done;
  logic              overflow_fail;
  logic [LEN_W-1:0]  total_length;

  modport source (output valid, out_byte, has_byte, packet_done, overflow_fail,
                  total_length, input ready);
  modport sink   (input valid, out_byte, has_byte, packet_done, overflow_fail,
                  total_length, output ready);
endinterface

[sv/zero_run_length_encoder_core.sv]
// zero run-length encoder core: input register, encode step, result group queue
// depends on zrle_pkg, zrle_in_if and zrle_out_if
//
//   channel   | dir | handshake     | beat carries
//   in_ch     | in  | valid/ready   | in_byte, end_of_packet, capacity
//   out_ch    | out | valid/ready   | out_byte, has_byte, packet_done, overflow_fail,
//             |     |               | total_length
//
// one input beat per cycle unless stalled; each byte gives 0 to 4 result beats
// result beats leave one per cycle while out_ch is ready; path: input register, queue
// results of one byte are queued together, 4 byte groups deep; input stalls only when
// the queue is full and the registered byte has results to push
// rst_n is synchronous; after reset the next byte starts a packet
module zero_run_length_encoder_core import zrle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  zrle_in_if.sink     in_ch,
  zrle_out_if.source  out_ch
);

  logic              a_valid_r;
  logic [BYTE_W-1:0] a_byte_r;
  logic              a_last_r;
  logic [LEN_W-1:0]  a_cap_r;

  logic              run_r;
  logic [BYTE_W-1:0] xcnt_r;
  logic [LEN_W-1:0]  ecnt_r;
  logic              failed_r;
  logic              pkt_start_r;
  logic [LEN_W-1:0]  cap_r;

  group_t            q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] q_cnt_r;
  logic [SLOT_W-1:0] sub_r;

  work_t             w;
  logic              a_adv;
  logic              push;
  logic              pop;
  logic              out_fire;
  group_t            head;
  res_t              head_res;

  // encode step for the registered byte
  always_comb begin
    w.grp = '0;
    if (pkt_start_r) begin
      w.run    = 1'b0;
      w.xcnt   = '0;
      w.ecnt   = '0;
      w.failed = 1'b0;
      w.cap    = (a_cap_r > LEN_W'(MAX_PKT_BYTES)) ? LEN_W'(MAX_PKT_BYTES) : a_cap_r;
    end else begin
      w.run    = run_r;
      w.xcnt   = xcnt_r;
      w.ecnt   = ecnt_r;
      w.failed = failed_r;
      w.cap    = cap_r;
    end
    if (a_byte_r == ZERO_MARK) begin
      priority if (!w.run) begin
        w = start_run(w);
      end else if (w.xcnt < RUN_MAX) begin
        w.xcnt = w.xcnt + BYTE_W'(1);
      end else begin
        w = close_run(w);
        w = start_run(w);
      end
    end else begin
      w = close_run(w);
      w = emit_byte(w, a_byte_r);
    end
    if (a_last_r) begin
      w = close_run(w);
      w = put_res(w, ZERO_MARK, 1'b0, 1'b1);
    end
  end

  assign a_adv       = a_valid_r && ((w.grp.n == '0) || (q_cnt_r != QCNT_W'(QDEPTH)));
  assign push        = a_adv && (w.grp.n != '0);
  assign in_ch.ready = !a_valid_r || a_adv;

  assign head     = q_mem_r[rd_ptr_r];
  assign head_res = head.res[sub_r];
  assign out_fire = out_ch.valid && out_ch.ready;
  assign pop      = out_fire && ({1'b0, sub_r} == (head.n - NRES_W'(1)));

  assign out_ch.valid         = (q_cnt_r != '0);
  assign out_ch.out_byte      = head_res.out_byte;
  assign out_ch.has_byte      = head_res.has_byte;
  assign out_ch.packet_done   = head_res.packet_done;
  assign out_ch.overflow_fail = head_res.overflow_fail;
  assign out_ch.total_length  = head_res.total_length;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_byte_r <= in_ch.in_byte;
      a_last_r <= in_ch.end_of_packet;
      a_cap_r  <= in_ch.capacity;
    end
  end

  // encoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      xcnt_r      <= '0;
      ecnt_r      <= '0;
      failed_r    <= 1'b0;
      pkt_start_r <= 1'b1;
      cap_r       <= '0;
    end else if (a_adv) begin
      run_r       <= w.run;
      xcnt_r      <= w.xcnt;
      ecnt_r      <= w.ecnt;
      failed_r    <= w.failed;
      pkt_start_r <= a_last_r;
      cap_r       <= w.cap;
    end
  end

  // result group queue
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= w.grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
      sub_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
        sub_r    <= '0;
      end else if (out_fire) begin
        sub_r <= sub_r + SLOT_W'(1);
      end
      q_cnt_r <= q_cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCNT_W'(QDEPTH))
    else $error("result queue over depth");

  a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (head.n != '0) && ({1'b0, sub_r} < head.n))
    else $error("queued group has no result at current slot");

  a_sub_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r == '0) |-> (sub_r == '0))
    else $error("slot index left over with empty queue");

  a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && a_last_r) |=> pkt_start_r)
    else $error("packet end did not rearm packet start");
`endif

endmodule

[tb/tb.sv]
// testbench for zero_run_length_encoder_core: packets of bytes in, encoded bytes and status out
// in-bench encoder model checks every result beat in order; random gaps and receiver stalls
// depends on zrle_pkg, zrle_in_if, zrle_out_if and the core
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import zrle_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eop;
    logic [LEN_W-1:0]  cap;
  } pkt_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  zrle_in_if  in_if();
  zrle_out_if out_if();

  zero_run_length_encoder_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #6 clk = ~clk;

  pkt_byte_t pending_bytes[$];
  pkt_byte_t cur_beat;
  res_t      expected_beats[$];
  res_t      want_beat;

  // encoder model state
  logic              run_on;
  logic [BYTE_W-1:0] zeros_extra;
  logic [LEN_W-1:0]  out_len;
  logic              overflowed;
  logic              new_packet;
  logic [LEN_W-1:0]  cap_limit;

  int n_total;
  int n_accepted = 0;
  int mismatches = 0;
  int in_gap = 0;
  int out_wait = 0;
  int rcv_beats = 0;
  int hold_left = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  bit start_hold;

  task automatic log_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic queue_result(input logic [BYTE_W-1:0] b, input logic has, input logic done);
    res_t r;
    r.out_byte      = b;
    r.has_byte      = has;
    r.packet_done   = done;
    r.overflow_fail = overflowed;
    r.total_length  = out_len;
    expected_beats.push_back(r);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if (!overflowed) begin
      if (out_len >= cap_limit) begin
        overflowed = 1'b1;
      end else begin
        out_len = out_len + LEN_W'(1);
        queue_result(b, 1'b1, 1'b0);
      end
    end
  endtask

  // marker needs room for its count byte as well
  task automatic open_zero_run();
    run_on      = 1'b1;
    zeros_extra = '0;
    if (!overflowed) begin
      if (({1'b0, out_len} + 13'd2) > {1'b0, cap_limit}) overflowed = 1'b1;
      else send_byte(ZERO_MARK);
    end
  endtask

  task automatic shut_zero_run();
    if (run_on) send_byte(zeros_extra);
    run_on      = 1'b0;
    zeros_extra = '0;
  endtask

  task automatic encode_byte(input pkt_byte_t p);
    if (new_packet) begin
      cap_limit   = (p.cap > MAX_PKT_BYTES) ? LEN_W'(MAX_PKT_BYTES) : p.cap;
      out_len     = '0;
      overflowed  = 1'b0;
      run_on      = 1'b0;
      zeros_extra = '0;
      new_packet  = 1'b0;
    end
    if (p.data == ZERO_MARK) begin
      if (!run_on) begin
        open_zero_run();
      end else if (zeros_extra < RUN_MAX) begin
        zeros_extra = zeros_extra + 8'd1;
      end else begin
        shut_zero_run();
        open_zero_run();
      end
    end else begin
      shut_zero_run();
      send_byte(p.data);
    end
    if (p.eop) begin
      shut_zero_run();
      queue_result('0, 1'b0, 1'b1);
      new_packet = 1'b1;
    end
  endtask

  task automatic add_beat(input logic [BYTE_W-1:0] b, input logic eop,
                          input logic [LEN_W-1:0] cap);
    pkt_byte_t p;
    p.data = b;
    p.eop  = eop;
    p.cap  = cap;
    pending_bytes.push_back(p);
  endtask

  task automatic add_random_packet();
    int len;
    int k;
    int seg;
    bit is_zero;
    logic [LEN_W-1:0] cap;
    logic [BYTE_W-1:0] b;
    len = $urandom_range(1, 14);
    case ($urandom_range(0, 7))
      0: cap = LEN_W'($urandom_range(0, 3));
      1: cap = LEN_W'($urandom_range(2049, 4095));
      2: cap = LEN_W'($urandom_range(1, 4095));
      default: cap = LEN_W'($urandom_range(1, 2 * len + 2));
    endcase
    k = 0;
    while (k < len) begin
      is_zero = 1'($urandom_range(0, 1));
      seg = is_zero ? $urandom_range(1, 5) : $urandom_range(1, 3);
      for (int j = 0; j < seg && k < len; j++) begin
        if (is_zero) b = ZERO_MARK;
        else if ($urandom_range(0, 7) == 0) b = 8'hFF;
        else b = BYTE_W'($urandom_range(1, 255));
        add_beat(b, k == len - 1, (k == 0) ? cap : LEN_W'($urandom));
        k++;
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap      = 0;
      run_on      = 1'b0;
      zeros_extra = '0;
      out_len     = '0;
      overflowed  = 1'b0;
      new_packet  = 1'b1;
      cap_limit   = '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        encode_byte(cur_beat);
        n_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (hold_left != 0) in_gap = 0;
        if (in_gap != 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          cur_beat = pending_bytes.pop_front();
          in_if.in_byte       <= cur_beat.data;
          in_if.end_of_packet <= cur_beat.eop;
          in_if.capacity      <= cur_beat.cap;
          in_if.valid         <= 1'b1;
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, 11);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with a long hold now and then so the input backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      out_wait     = 0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      start_hold = 1'b0;
      if (out_if.valid && out_if.ready) begin
        rcv_beats++;
        start_hold = (rcv_beats % 250 == 30);
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_wait = out_burst ? 0 : $urandom_range(0, 11);
      end else if (out_wait != 0) begin
        out_wait--;
      end
      if (start_hold) begin
        hold_left    <= 90;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= (out_wait == 0);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_beats.size() == 0) begin
        log_mismatch($sformatf("result beat with nothing expected, byte %02h done %0b",
                               out_if.out_byte, out_if.packet_done));
      end else begin
        want_beat = expected_beats.pop_front();
        if (out_if.out_byte !== want_beat.out_byte || out_if.has_byte !== want_beat.has_byte ||
            out_if.packet_done !== want_beat.packet_done ||
            out_if.overflow_fail !== want_beat.overflow_fail ||
            out_if.total_length !== want_beat.total_length)
          log_mismatch($sformatf(
            "got byte %02h has %0b done %0b fail %0b len %0d, want %02h %0b %0b %0b %0d",
            out_if.out_byte, out_if.has_byte, out_if.packet_done, out_if.overflow_fail,
            out_if.total_length, want_beat.out_byte, want_beat.has_byte,
            want_beat.packet_done, want_beat.overflow_fail, want_beat.total_length));
      end
    end
  end

  initial begin
    int base;
    int run_len;
    logic [LEN_W-1:0] cap_pick;
    in_if.valid         = 1'b0;
    in_if.in_byte       = '0;
    in_if.end_of_packet = 1'b0;
    in_if.capacity      = '0;
    out_if.ready        = 1'b0;
    rst_n               = 1'b0;

    // single-byte packets: zero run with clamped capacity, then no room at all
    add_beat(8'h00, 1'b1, 12'hFFF);
    add_beat(8'hFF, 1'b1, 12'h000);
    // no room for marker plus count
    add_beat(8'h05, 1'b0, 12'd1);
    add_beat(8'h00, 1'b1, 12'd1);
    // output filled exactly
    add_beat(8'h00, 1'b0, 12'd3);
    add_beat(8'h00, 1'b0, 12'd3);
    add_beat(8'h07, 1'b1, 12'd3);
    // byte dropped on full output
    add_beat(8'h11, 1'b0, 12'd3);
    add_beat(8'h22, 1'b0, 12'd0);
    add_beat(8'h33, 1'b0, 12'hFFF);
    add_beat(8'h44, 1'b1, 12'd3);
    // runs still tracked after failure
    add_beat(8'h09, 1'b0, 12'd2);
    add_beat(8'h00, 1'b0, 12'd2);
    add_beat(8'h00, 1'b0, 12'd2);
    add_beat(8'h0A, 1'b0, 12'd2);
    add_beat(8'h00, 1'b1, 12'd2);
    // capacity at the maximum
    add_beat(8'h80, 1'b0, 12'h800);
    add_beat(8'h00, 1'b0, 12'h7FF);
    add_beat(8'h01, 1'b1, 12'h800);

    base = pending_bytes.size();
    while (pending_bytes.size() < base + 35) add_random_packet();
    // one run around the 256-zero wrap
    run_len  = $urandom_range(256, 260);
    cap_pick = LEN_W'($urandom_range(8, 2048));
    add_beat(BYTE_W'($urandom_range(1, 255)), 1'b0, cap_pick);
    for (int i = 0; i < run_len; i++) add_beat(8'h00, 1'b0, LEN_W'($urandom));
    add_beat(BYTE_W'($urandom_range(1, 255)), 1'b0, LEN_W'($urandom));
    add_beat(8'h00, 1'b1, LEN_W'($urandom));
    base = pending_bytes.size();
    while (pending_bytes.size() < base + 35) add_random_packet();
    n_total = pending_bytes.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (n_accepted < n_total) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[zero_run_length_encoder_core] OK");
    end else begin
      $display("[zero_run_length_encoder_core] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[zero_run_length_encoder_core] ERROR");
    $finish;
  end

endmodule
